FILE: hdl/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types, constants and the gamma threshold builder for the pixel
// color correction pipeline.
// ----------------------------------------------------------------------------
package ccp_pkg;

    localparam int TABLE_DEPTH    = 256;
    localparam int LUT_ADDR_W     = 8;
    localparam int LIN_W          = 16;   // linear light, unsigned Q0.16
    localparam int COEF_W         = 16;   // signed matrix coefficient
    localparam int MATRIX_ENTRIES = 9;
    localparam int COEF_IDX_W     = 4;
    localparam int PIX_W          = 8;
    localparam int PROD_W         = COEF_W + LIN_W + 1;
    localparam int SUM_W          = PROD_W + 1;   // three products never need more
    localparam int GQ_MAX_W       = 17;           // widest gamma index plus one
    localparam int STEPS_PER_STAGE = 2;
    localparam int ENC_STAGES     = PIX_W / STEPS_PER_STAGE;
    localparam int CODE_COUNT     = 1 << PIX_W;

    // sRGB encode, scaled to integers:
    //   255*(1.055*x^(5/12) - 0.055) >= v  <=>  10761*x^(5/12) >= 40*v + 561
    // raised to the 12th power to clear the root.
    localparam int GAMMA_NUM  = 10761;
    localparam int GAMMA_STEP = 40;
    localparam int GAMMA_OFF  = 561;
    localparam int GAMMA_ROOT = 12;
    localparam int GAMMA_POW  = 5;
    // Linear toe: x <= 0.0031308, output 255*12.92*x = 16473/5 * x.
    localparam longint LIN_KNEE_NUM  = 31308;
    localparam longint LIN_KNEE_DEN  = 10000000;
    localparam longint LIN_SLOPE_NUM = 16473;
    localparam longint LIN_SLOPE_DEN = 5;
    localparam int BIG_W = 256;

    typedef enum logic [1:0] {
        OP_PIXEL       = 2'd0,
        OP_LOAD_TABLE  = 2'd1,
        OP_LOAD_MATRIX = 2'd2
    } opcode_t;

    typedef struct packed {
        opcode_t                opcode;
        logic [PIX_W-1:0]       red_in;
        logic [PIX_W-1:0]       green_in;
        logic [PIX_W-1:0]       blue_in;
        logic [LUT_ADDR_W-1:0]  entry_index;
        logic [LIN_W-1:0]       entry_value;
    } pixel_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
    } pixel_rsp_t;

    // Entry v: smallest gamma index q whose encoded code reaches v.
    typedef logic [CODE_COUNT-1:0][GQ_MAX_W-1:0] gamma_thr_table_t;

    // Elaboration only. Exact integer decision per code, binary search over q.
    function automatic gamma_thr_table_t gamma_thresholds(input int gib);
        gamma_thr_table_t tbl;
        logic [BIG_W-1:0] l12;
        logic [BIG_W-1:0] r12;
        logic [BIG_W-1:0] qp;
        logic [BIG_W-1:0] lhs;
        logic [BIG_W-1:0] rhs;
        longint full;
        longint lo;
        longint hi;
        longint mid;
        bit     pred;
        int     v;
        int     i;
        tbl  = '0;
        full = longint'(1) << gib;
        l12  = BIG_W'(1);
        for (i = 0; i < GAMMA_ROOT; i++) begin
            l12 = l12 * BIG_W'(GAMMA_NUM);
        end
        for (v = 1; v < CODE_COUNT; v++) begin
            r12 = BIG_W'(1);
            for (i = 0; i < GAMMA_ROOT; i++) begin
                r12 = r12 * BIG_W'(GAMMA_STEP * v + GAMMA_OFF);
            end
            lo = 0;
            hi = full;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (mid * LIN_KNEE_DEN <= LIN_KNEE_NUM * full) begin
                    pred = (LIN_SLOPE_NUM * mid >= longint'(v) * LIN_SLOPE_DEN * full);
                end
                else begin
                    qp = BIG_W'(1);
                    for (i = 0; i < GAMMA_POW; i++) begin
                        qp = qp * BIG_W'(mid);
                    end
                    lhs  = l12 * qp;
                    rhs  = r12 << (GAMMA_POW * gib);
                    pred = (lhs >= rhs);
                end
                if (pred) begin
                    hi = mid;
                end
                else begin
                    lo = mid + 1;
                end
            end
            tbl[v] = GQ_MAX_W'(lo);
        end
        return tbl;
    endfunction

endpackage

FILE: hdl/ccp_lut_ram.sv
// ----------------------------------------------------------------------------
// ccp_lut_ram
// Response table copy: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ccp_lut_ram (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ccp_pkg::LUT_ADDR_W-1:0] wr_addr,
    input  logic [ccp_pkg::LIN_W-1:0]      wr_data,
    input  logic                          rd_en,
    input  logic [ccp_pkg::LUT_ADDR_W-1:0] rd_addr,
    output logic [ccp_pkg::LIN_W-1:0]      rd_data
);
    import ccp_pkg::*;

    logic [LIN_W-1:0] mem [TABLE_DEPTH];
    logic [LIN_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/ccp_gamma_encode.sv
// ----------------------------------------------------------------------------
// ccp_gamma_encode
// sRGB encode of one channel: pipelined binary search of the code threshold
// table, two code bits per stage.
// ----------------------------------------------------------------------------
module ccp_gamma_encode #(
    parameter int GAMMA_INDEX_BITS = 12
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [GAMMA_INDEX_BITS:0]   q_in,
    output logic [ccp_pkg::PIX_W-1:0]   code_out
);
    import ccp_pkg::*;

    localparam int GQ_W = GAMMA_INDEX_BITS + 1;
    localparam gamma_thr_table_t THR = gamma_thresholds(GAMMA_INDEX_BITS);

    logic [GQ_W-1:0]  q_src     [ENC_STAGES];
    logic [PIX_W-1:0] code_src  [ENC_STAGES];
    logic [PIX_W-1:0] code_next [ENC_STAGES];
    logic [PIX_W-1:0] code_reg  [ENC_STAGES];
    logic [GQ_W-1:0]  q_reg     [ENC_STAGES-1];

    // Try each bit from the top; keep it if q reaches that code's threshold.
    function automatic logic [PIX_W-1:0] search_steps(
        input logic [GQ_W-1:0]  q,
        input logic [PIX_W-1:0] code,
        input int               top_bit
    );
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] cand;
        c = code;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            cand = c | (PIX_W'(1) << (top_bit - k));
            if (q >= THR[cand][GQ_W-1:0])
            begin
                c = cand;
            end
        end
        return c;
    endfunction

    for (genvar s = 0; s < ENC_STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            assign q_src[s]    = q_in;
            assign code_src[s] = '0;
        end
        else
        begin : g_rest
            assign q_src[s]    = q_reg[s-1];
            assign code_src[s] = code_reg[s-1];
        end
        assign code_next[s] = search_steps(q_src[s], code_src[s],
                                           PIX_W - 1 - s * STEPS_PER_STAGE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code_reg <= code_next;
            for (int s = 0; s < ENC_STAGES - 1; s++)
            begin
                q_reg[s] <= q_src[s];
            end
        end
    end

    assign code_out = code_reg[ENC_STAGES-1];

endmodule

FILE: hdl/camera_color_correction_pixel.sv
// ----------------------------------------------------------------------------
// camera_color_correction_pixel
// Pipeline: table read, multiply, row sum, gamma index, four gamma search
//   stages, from request to result; loads give no result.
// Throughput: one request per cycle; the whole pipe holds when the result
//   register is full and not taken.
// Reset: clears the pipeline valid bits only; response table and matrix
//   hold nothing defined until loaded.
// ----------------------------------------------------------------------------
module camera_color_correction_pixel #(
    parameter int COEF_FRAC_BITS   = 12,
    parameter int GAMMA_INDEX_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ccp_pkg::pixel_req_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ccp_pkg::pixel_rsp_t out_data
);
    import ccp_pkg::*;

    localparam int GQ_W        = GAMMA_INDEX_BITS + 1;
    // Row sums carry 16 + COEF_FRAC_BITS fraction bits; keep the top
    // GAMMA_INDEX_BITS of the fraction as the gamma index.
    localparam int SUM_SHIFT   = LIN_W + COEF_FRAC_BITS - GAMMA_INDEX_BITS;
    localparam int SH_W        = SUM_W - SUM_SHIFT;
    localparam int PIPE_STAGES = 4 + ENC_STAGES;
    localparam logic [GQ_W-1:0] Q_FULL = {1'b1, {GAMMA_INDEX_BITS{1'b0}}};

    // Global advance: every stage moves when the result register can drain.
    logic adv;
    logic in_acc;
    logic pix_acc;
    logic tbl_wr;
    logic mtx_wr;

    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;

    logic [LIN_W-1:0]         lin       [3];
    logic [COEF_W-1:0]        coef_reg  [MATRIX_ENTRIES];
    logic signed [PROD_W-1:0] prod_next [MATRIX_ENTRIES];
    logic signed [PROD_W-1:0] prod_reg  [MATRIX_ENTRIES];
    logic signed [SUM_W-1:0]  sum_next  [3];
    logic signed [SUM_W-1:0]  sum_reg   [3];
    logic [GQ_W-1:0]          q_next    [3];
    logic [GQ_W-1:0]          q_reg     [3];
    logic [PIX_W-1:0]         code      [3];
    logic [PIX_W-1:0]         pix_in    [3];

    assign adv      = !vld_reg[PIPE_STAGES-1] || out_ready;
    assign in_ready = adv;
    assign in_acc   = in_valid && in_ready;

    // Request decode. Reserved opcode falls through: no write, no result.
    always_comb
    begin
        pix_acc = 1'b0;
        tbl_wr  = 1'b0;
        mtx_wr  = 1'b0;
        if (in_acc)
        begin
            unique case (in_data.opcode)
                OP_PIXEL:       pix_acc = 1'b1;
                OP_LOAD_TABLE:  tbl_wr  = 1'b1;
                OP_LOAD_MATRIX: mtx_wr  = (in_data.entry_index < LUT_ADDR_W'(MATRIX_ENTRIES));
                default:        ;
            endcase
        end
    end

    // Valid bits ride along with the data.
    assign vld_next = {vld_reg[PIPE_STAGES-2:0], pix_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: response table lookup. One copy per channel so all three
    // reads happen in the same cycle; every table load writes all copies.
    // A load accepted in the cycle before a pixel is already visible to it.
    assign pix_in[0] = in_data.red_in;
    assign pix_in[1] = in_data.green_in;
    assign pix_in[2] = in_data.blue_in;

    for (genvar c = 0; c < 3; c++)
    begin : g_lut
        ccp_lut_ram u_lut (
            .clk     (clk),
            .wr_en   (tbl_wr),
            .wr_addr (in_data.entry_index),
            .wr_data (in_data.entry_value),
            .rd_en   (adv),
            .rd_addr (pix_in[c]),
            .rd_data (lin[c])
        );
    end

    // Matrix coefficients. A pixel uses them exactly one advance after it
    // was accepted, so a matrix load written at acceptance never reaches
    // an older pixel.
    always_ff @(posedge clk)
    begin
        if (mtx_wr)
        begin
            coef_reg[in_data.entry_index[COEF_IDX_W-1:0]] <= in_data.entry_value;
        end
    end

    // Stage 2: nine signed products, coefficient times unsigned linear value.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[3*r+c] = signed'(coef_reg[3*r+c]) * signed'({1'b0, lin[c]});
            end
        end
    end

    // Stage 3: row sums, one per output channel.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = prod_reg[3*r] + prod_reg[3*r+1] + prod_reg[3*r+2];
        end
    end

    // Stage 4: gamma index. Non-positive sums go to zero, anything at or
    // above 1.0 saturates to the full-scale index.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            if (sum_reg[r][SUM_W-1] || (sum_reg[r] == '0))
            begin
                q_next[r] = '0;
            end
            else if (sum_reg[r][SUM_W-1:SUM_SHIFT] > SH_W'(Q_FULL))
            begin
                q_next[r] = Q_FULL;
            end
            else
            begin
                q_next[r] = sum_reg[r][SUM_SHIFT+GQ_W-1:SUM_SHIFT];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
            q_reg    <= q_next;
        end
    end

    // Stages 5 to 8: gamma encode per channel; last stage is the result register.
    for (genvar r = 0; r < 3; r++)
    begin : g_enc
        ccp_gamma_encode #(
            .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
        ) u_enc (
            .clk      (clk),
            .en       (adv),
            .q_in     (q_reg[r]),
            .code_out (code[r])
        );
    end

    assign out_valid          = vld_reg[PIPE_STAGES-1];
    assign out_data.red_out   = code[0];
    assign out_data.green_out = code[1];
    assign out_data.blue_out  = code[2];

endmodule
